// ----- hdl/ordered_key_list_engine_assert.svh -----
// Assertion macros for the ordered key list engine
`ifndef ORDERED_KEY_LIST_ENGINE_ASSERT_SVH
`define ORDERED_KEY_LIST_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define OKL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define OKL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define OKL_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define OKL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/okl_pkg.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// okl_pkg
// Shared types and constants of the ordered key list engine.
// -----------------------------------------------------------------------------
package okl_pkg;
    localparam int Capacity = 32;
    localparam int SlotW = $clog2(Capacity);
    localparam int CountW = $clog2(Capacity + 1);

    localparam logic [3:0] REQ_CLEAR  = 4'd0;
    localparam logic [3:0] REQ_INSERT = 4'd1;
    localparam logic [3:0] REQ_DELETE = 4'd2;
    localparam logic [3:0] REQ_PUSH_B = 4'd3;
    localparam logic [3:0] REQ_POP_B  = 4'd4;
    localparam logic [3:0] REQ_PUSH_F = 4'd5;
    localparam logic [3:0] REQ_POP_F  = 4'd6;
    localparam logic [3:0] REQ_REV    = 4'd7;
    localparam logic [3:0] REQ_DUMP   = 4'd8;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_CHK, S_LINK1, S_LINK2, S_UNLINK1, S_UNLINK2,
        S_REV, S_DUMP, S_RESP
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch request, start walk at front (back for pop back)
        logic clear;
        logic rd;        // read key and links of cursor slot
        logic adv;       // cursor <- next (prev for reverse), index++
        logic link_a;    // first link write phase
        logic link_b;    // second link write phase
        logic unlink_a;
        logic unlink_b;
        logic rev_step;
        logic emit;
        logic [1:0] st;
        logic last;
        logic dump_item;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
        logic hit;       // key match or ge per request
        logic at_end;    // index reached count-1
    } t_stat;
endpackage

// ----- hdl/okl_ctrl.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// okl_ctrl
// Request sequencer of the ordered key list engine.
// -----------------------------------------------------------------------------
module okl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [3:0]        i_req_type,
    input  okl_pkg::t_stat    i_stat,
    output logic              busy,
    output okl_pkg::t_cmd     o_cmd
);
    import okl_pkg::*;

    t_state r_state, n_state;
    logic [3:0] r_req, n_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_req   <= REQ_CLEAR;
        end else begin
            r_state <= n_state;
            r_req   <= n_req;
        end
    end

    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        o_cmd   = '0;
        busy    = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req = i_req_type;
                    o_cmd.load = 1'b1;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                // link data and cursor reads settle here
                o_cmd.rd = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                n_state = S_RESP;
                o_cmd.st = ST_OK;
                case (r_req)
                    REQ_CLEAR: o_cmd.clear = 1'b1;
                    REQ_INSERT, REQ_PUSH_B, REQ_PUSH_F: begin
                        if (i_stat.full) begin
                            o_cmd.st = ST_FULL;
                            o_cmd.emit = 1'b1;
                            o_cmd.last = 1'b1;
                            n_state = S_IDLE;
                        end else if (r_req == REQ_INSERT && !i_stat.empty
                                     && !i_stat.hit && !i_stat.at_end) begin
                            o_cmd.adv = 1'b1;
                            n_state = S_RD;
                        end else begin
                            n_state = S_LINK1;
                        end
                    end
                    REQ_DELETE, REQ_POP_B, REQ_POP_F: begin
                        if (i_stat.empty) begin
                            o_cmd.st = ST_EMPTY;
                            o_cmd.emit = 1'b1;
                            o_cmd.last = 1'b1;
                            n_state = S_IDLE;
                        end else if (r_req != REQ_DELETE || i_stat.hit) begin
                            n_state = S_UNLINK1;
                        end else if (i_stat.at_end) begin
                            o_cmd.st = ST_NOTFOUND;
                            o_cmd.emit = 1'b1;
                            o_cmd.last = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.adv = 1'b1;
                            n_state = S_RD;
                        end
                    end
                    REQ_REV: begin
                        if (i_stat.empty) begin
                            o_cmd.st = ST_EMPTY;
                            o_cmd.emit = 1'b1;
                            o_cmd.last = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_REV;
                        end
                    end
                    REQ_DUMP: begin
                        if (i_stat.empty) begin
                            o_cmd.st = ST_EMPTY;
                            o_cmd.emit = 1'b1;
                            o_cmd.last = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_DUMP;
                        end
                    end
                    default: ;
                endcase
            end
            S_LINK1: begin
                o_cmd.link_a = 1'b1;
                n_state = S_LINK2;
            end
            S_LINK2: begin
                o_cmd.link_b = 1'b1;
                n_state = S_RESP;
            end
            S_UNLINK1: begin
                o_cmd.unlink_a = 1'b1;
                n_state = S_UNLINK2;
            end
            S_UNLINK2: begin
                o_cmd.unlink_b = 1'b1;
                n_state = S_RESP;
            end
            S_REV: begin
                o_cmd.rev_step = 1'b1;
                if (i_stat.at_end) begin
                    n_state = S_RESP;
                end else begin
                    o_cmd.adv = 1'b1;
                    n_state = S_RD;
                end
            end
            S_DUMP: begin
                o_cmd.emit = 1'b1;
                o_cmd.dump_item = 1'b1;
                o_cmd.st = ST_OK;
                o_cmd.last = i_stat.at_end;
                if (i_stat.at_end) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.adv = 1'b1;
                    n_state = S_RD;
                end
            end
            S_RESP: begin
                o_cmd.emit = 1'b1;
                o_cmd.st = ST_OK;
                o_cmd.last = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        // walk loops return through S_RD; rev and dump skip the check once the list has keys
        if (r_state == S_RD && r_req == REQ_REV && !i_stat.empty) n_state = S_REV;
        if (r_state == S_RD && r_req == REQ_DUMP && !i_stat.empty) n_state = S_DUMP;
    end
endmodule

// ----- hdl/okl_dp.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// okl_dp
// Key store, link tables, free map and walk cursor.
// -----------------------------------------------------------------------------
module okl_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [3:0]           i_req_type,
    input  logic signed [31:0]   i_key,
    input  okl_pkg::t_cmd        i_cmd,
    output okl_pkg::t_stat       o_stat,
    output logic                 o_valid,
    output logic [1:0]           o_status,
    output logic [6:0]           o_entry_count,
    output logic signed [31:0]   o_item_key,
    output logic [5:0]           o_item_index,
    output logic                 o_last
);
    import okl_pkg::*;

    logic [31:0]      key_mem [Capacity];
    logic [SlotW-1:0] nxt_mem [Capacity];
    logic [SlotW-1:0] prv_mem [Capacity];

    logic [Capacity-1:0] r_free;
    logic [SlotW-1:0]    r_front, r_back, r_cur, r_new;
    logic [CountW-1:0]   r_count;
    logic [CountW-1:0]   r_idx;
    logic [3:0]          r_req;
    logic [31:0]         r_key;
    logic [31:0]         r_rd_key;
    logic [SlotW-1:0]    r_rd_nxt, r_rd_prv;

    logic [SlotW-1:0] w_low_free;
    always_comb begin
        w_low_free = '0;
        for (int i = Capacity - 1; i >= 0; i--) begin
            if (r_free[i]) w_low_free = SlotW'(i);
        end
    end

    logic w_ge, w_eq;
    assign w_ge = $signed(r_rd_key) >= $signed(r_key);
    assign w_eq = r_rd_key == r_key;

    assign o_stat.empty  = (r_count == '0);
    assign o_stat.full   = (r_count == CountW'(Capacity));
    assign o_stat.hit    = (r_req == REQ_INSERT) ? w_ge : w_eq;
    assign o_stat.at_end = (r_idx + 1'b1 == r_count);

    // memory reads (registered)
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_key <= key_mem[r_cur];
            r_rd_nxt <= nxt_mem[r_cur];
            r_rd_prv <= prv_mem[r_cur];
        end
    end

    // a sorted insert that found no key >= its own goes after the back,
    // i.e. between the cursor (back) and its next (front)
    logic             w_append;
    logic [SlotW-1:0] w_lnk_n, w_lnk_p;
    logic             w_new_front, w_new_back;
    assign w_append    = (r_req == REQ_INSERT) && !w_ge;
    assign w_lnk_n     = w_append ? r_rd_nxt : r_cur;
    assign w_lnk_p     = w_append ? r_cur : r_rd_prv;
    assign w_new_front = (r_req == REQ_PUSH_F) ||
                         ((r_req == REQ_INSERT) && !w_append && (r_idx == '0));
    assign w_new_back  = (r_req == REQ_PUSH_B) || w_append;

    // memory writes, one write port per table per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.link_a) begin
            key_mem[r_new] <= r_key;
            if (r_count == '0) begin
                nxt_mem[r_new] <= r_new;
            end else begin
                nxt_mem[r_new] <= w_lnk_n;
                prv_mem[w_lnk_n] <= r_new;
            end
        end
        if (i_cmd.link_b) begin
            if (r_count == '0) begin
                prv_mem[r_new] <= r_new;
            end else begin
                nxt_mem[w_lnk_p] <= r_new;
                prv_mem[r_new] <= w_lnk_p;
            end
        end
        if (i_cmd.unlink_a) nxt_mem[r_rd_prv] <= r_rd_nxt;
        if (i_cmd.unlink_b) prv_mem[r_rd_nxt] <= r_rd_prv;
        if (i_cmd.rev_step) begin
            nxt_mem[r_cur] <= r_rd_prv;
            prv_mem[r_cur] <= r_rd_nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free  <= '1;
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit;
            if (i_cmd.clear) begin
                r_free  <= '1;
                r_front <= '0;
                r_back  <= '0;
                r_count <= '0;
            end else if (i_cmd.link_b) begin
                r_count <= r_count + 1'b1;
                r_free[r_new] <= 1'b0;
                if (r_count == '0) begin
                    r_front <= r_new;
                    r_back  <= r_new;
                end else begin
                    if (w_new_front) r_front <= r_new;
                    if (w_new_back)  r_back  <= r_new;
                end
            end else if (i_cmd.unlink_b) begin
                r_count <= r_count - 1'b1;
                r_free[r_cur] <= 1'b1;
                if (r_count == CountW'(1)) begin
                    r_front <= '0;
                    r_back  <= '0;
                end else begin
                    if (r_cur == r_front) r_front <= r_rd_nxt;
                    if (r_cur == r_back)  r_back  <= r_rd_prv;
                end
            end else if (i_cmd.rev_step && o_stat.at_end) begin
                r_front <= r_back;
                r_back  <= r_front;
            end
        end
    end

    // cursor and request latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req_type;
            r_key <= i_key;
            r_idx <= '0;
            r_new <= w_low_free;
            r_cur <= (i_req_type == REQ_POP_B) ? r_back : r_front;
        end else if (i_cmd.adv) begin
            r_cur <= (r_req == REQ_REV) ? r_rd_prv : r_rd_nxt;
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_status      <= i_cmd.st;
            o_last        <= i_cmd.last;
            o_item_key    <= i_cmd.dump_item ? r_rd_key : '0;
            o_item_index  <= i_cmd.dump_item ? 6'(r_idx) : '0;
            o_entry_count <= 7'(r_count);
        end
    end
endmodule

// ----- hdl/ordered_key_list_engine.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ordered_key_list_engine
// Bounded ordered list of signed keys with a walk sequencer.
// -----------------------------------------------------------------------------
// A request (i_req_type, i_key) is taken when start is high and busy is low.
// Results appear with o_valid for one cycle each; the receiver cannot stall.
// Every request gives one result, except a non-empty dump which gives one
// result per stored key, front first, with o_last on the final one.
// Sorted insert, delete by key, reverse and dump walk the list one entry at
// a time through the registered link memory read.
// busy drops in the cycle the final result is out, so the next request can
// be taken at the edge that ends it.
// Reset empties the list and frees every slot at once; no clearing pass.
// -----------------------------------------------------------------------------
`include "ordered_key_list_engine_assert.svh"
module ordered_key_list_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         i_req_type,
    input  logic signed [31:0] i_key,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic [6:0]         o_entry_count,
    output logic signed [31:0] o_item_key,
    output logic [5:0]         o_item_index,
    output logic               o_last
);
    import okl_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    okl_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start),
        .i_req_type(i_req_type), .i_stat(w_stat), .busy(busy), .o_cmd(w_cmd)
    );

    okl_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req_type(i_req_type),
        .i_key(i_key), .i_cmd(w_cmd), .o_stat(w_stat), .o_valid(o_valid),
        .o_status(o_status), .o_entry_count(o_entry_count),
        .o_item_key(o_item_key), .o_item_index(o_item_index), .o_last(o_last)
    );

    `OKL_ASSERT_IMPL(a_full_cap, i_clk, i_rst_n, o_valid, o_entry_count <= 7'(Capacity))
    `OKL_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, start && !busy, busy)
    `OKL_ASSERT_IMPL(a_full_status, i_clk, i_rst_n, o_valid && o_status == ST_FULL,
        o_entry_count == 7'(Capacity))
endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// testbench
// Checks the ordered key list engine against a behavioral list kept in
// queues: directed corner requests, then random request mixes under several
// idle patterns on the request side. Every result word is checked in order.
// -----------------------------------------------------------------------------
module testbench;
    import okl_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [3:0]         i_req_type;
    logic signed [31:0] i_key;
    logic               o_valid;
    logic [1:0]         o_status;
    logic [6:0]         o_entry_count;
    logic signed [31:0] o_item_key;
    logic [5:0]         o_item_index;
    logic               o_last;

    typedef struct {
        logic [1:0]  status;
        logic [6:0]  count;
        logic [31:0] item_key;
        logic [5:0]  item_index;
        logic        last;
    } t_word;

    logic signed [31:0] list_keys[$];
    t_word              pending_words[$];
    int                 idle_pct;
    bit                 failed;

    ordered_key_list_engine uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_key(i_key), .o_valid(o_valid),
        .o_status(o_status), .o_entry_count(o_entry_count),
        .o_item_key(o_item_key), .o_item_index(o_item_index), .o_last(o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("testbench: FAIL");
        $finish;
    end

    function automatic t_word status_word(logic [1:0] st);
        t_word w;
        w.status = st;
        w.count = 7'(list_keys.size());
        w.item_key = '0;
        w.item_index = '0;
        w.last = 1'b1;
        return w;
    endfunction

    // Apply one request to the list and queue the words it should produce.
    task automatic predict_request(logic [3:0] req, logic signed [31:0] k);
        logic [1:0] st;
        int pos;
        t_word w;
        st = ST_OK;
        case (req)
            REQ_CLEAR: list_keys.delete();
            REQ_INSERT, REQ_PUSH_B, REQ_PUSH_F: begin
                if (list_keys.size() >= Capacity) begin
                    st = ST_FULL;
                end else if (req == REQ_PUSH_B) begin
                    list_keys.push_back(k);
                end else if (req == REQ_PUSH_F) begin
                    list_keys.push_front(k);
                end else begin
                    pos = list_keys.size();
                    for (int i = list_keys.size() - 1; i >= 0; i--)
                        if (list_keys[i] >= k) pos = i;
                    list_keys.insert(pos, k);
                end
            end
            REQ_DELETE: begin
                if (list_keys.size() == 0) begin
                    st = ST_EMPTY;
                end else begin
                    pos = -1;
                    for (int i = list_keys.size() - 1; i >= 0; i--)
                        if (list_keys[i] == k) pos = i;
                    if (pos < 0) st = ST_NOTFOUND;
                    else list_keys.delete(pos);
                end
            end
            REQ_POP_B, REQ_POP_F, REQ_REV: begin
                if (list_keys.size() == 0) st = ST_EMPTY;
                else if (req == REQ_POP_B) void'(list_keys.pop_back());
                else if (req == REQ_POP_F) void'(list_keys.pop_front());
                else list_keys.reverse();
            end
            REQ_DUMP: begin
                if (list_keys.size() == 0) st = ST_EMPTY;
            end
            default: ;
        endcase
        if (req == REQ_DUMP && list_keys.size() != 0) begin
            foreach (list_keys[i]) begin
                w.status = ST_OK;
                w.count = 7'(list_keys.size());
                w.item_key = list_keys[i];
                w.item_index = 6'(i);
                w.last = (i == list_keys.size() - 1);
                pending_words.push_back(w);
            end
        end else begin
            pending_words.push_back(status_word(st));
        end
    endtask

    task automatic send_request(logic [3:0] req, logic signed [31:0] k);
        while ($urandom_range(99) < idle_pct) @(negedge i_clk);
        start = 1'b1;
        i_req_type = req;
        i_key = k;
        // hold the word until an edge that sees busy low
        do @(posedge i_clk); while (busy);
        predict_request(req, k);
        @(negedge i_clk);
        start = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_word w;
        if (i_rst_n && o_valid) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word status=%0d key=%0d", $time, o_status,
                         o_item_key);
                failed = 1'b1;
            end else begin
                w = pending_words.pop_front();
                if (o_status !== w.status || o_entry_count !== w.count ||
                    o_item_key !== w.item_key || o_item_index !== w.item_index ||
                    o_last !== w.last) begin
                    $display("%0t: mismatch expected st=%0d cnt=%0d key=%0d idx=%0d last=%0d",
                             $time, w.status, w.count, $signed(w.item_key),
                             w.item_index, w.last);
                    $display("%0t:            actual st=%0d cnt=%0d key=%0d idx=%0d last=%0d",
                             $time, o_status, o_entry_count, o_item_key,
                             o_item_index, o_last);
                    failed = 1'b1;
                end
            end
        end
    end

    function automatic logic signed [31:0] pick_key();
        case ($urandom_range(5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $urandom();
            3: return (list_keys.size() != 0) ? list_keys[$urandom_range(list_keys.size() - 1)]
                                              : 32'sd0;
            default: return $signed(32'($urandom_range(40))) - 20;
        endcase
    endfunction

    task automatic test_corners();
        logic [3:0] req;
        send_request(REQ_DUMP, 0);
        send_request(REQ_DELETE, 5);
        send_request(REQ_POP_B, 0);
        send_request(REQ_POP_F, 0);
        send_request(REQ_REV, 0);
        send_request(REQ_INSERT, 32'sh7fff_ffff);
        send_request(REQ_INSERT, 32'sh8000_0000);
        send_request(REQ_INSERT, 0);
        send_request(REQ_INSERT, 0);
        send_request(REQ_PUSH_F, -1);
        send_request(REQ_PUSH_B, 32'sh5555_aaaa);
        send_request(REQ_DELETE, 123);
        send_request(REQ_DELETE, 0);
        send_request(REQ_REV, 0);
        send_request(REQ_DUMP, 0);
        send_request(REQ_POP_B, 0);
        send_request(REQ_POP_F, 0);
        req = 4'(REQ_DUMP + 1);
        send_request(req, 32'shffff_ffff);
        send_request(4'hf, 0);
        send_request(REQ_CLEAR, 0);
        send_request(REQ_DUMP, 0);
    endtask

    // Fill to capacity so the full status and the longest dump are hit.
    task automatic test_full_list();
        while (list_keys.size() < Capacity)
            send_request(($urandom_range(1)) ? REQ_INSERT : REQ_PUSH_F, pick_key());
        send_request(REQ_INSERT, 1);
        send_request(REQ_PUSH_B, 2);
        send_request(REQ_PUSH_F, 3);
        send_request(REQ_DUMP, 0);
        send_request(REQ_REV, 0);
        send_request(REQ_DUMP, 0);
        send_request(REQ_CLEAR, 0);
    endtask

    task automatic test_random_mix(int n_reqs);
        int r;
        logic [3:0] req;
        for (int i = 0; i < n_reqs; i++) begin
            r = $urandom_range(99);
            if (r < 30) req = REQ_INSERT;
            else if (r < 42) req = REQ_DELETE;
            else if (r < 50) req = REQ_PUSH_B;
            else if (r < 58) req = REQ_PUSH_F;
            else if (r < 66) req = REQ_POP_B;
            else if (r < 74) req = REQ_POP_F;
            else if (r < 80) req = REQ_REV;
            else if (r < 92) req = REQ_DUMP;
            else if (r < 95) req = REQ_CLEAR;
            else req = 4'($urandom_range(15, 9));
            send_request(req, pick_key());
        end
    endtask

    initial begin
        failed = 1'b0;
        idle_pct = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req_type = REQ_CLEAR;
        i_key = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_corners();
        test_full_list();
        idle_pct = 0;
        test_random_mix(35);
        idle_pct = 52;
        test_random_mix(35);
        idle_pct = 8;
        test_random_mix(35);
        idle_pct = 0;
        test_random_mix(20);

        for (int t = 0; t < 1000 && pending_words.size() != 0; t++) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (!failed && pending_words.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            if (pending_words.size() != 0)
                $display("%0t: %0d words never arrived", $time, pending_words.size());
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule
